@@ rtl/core/u8d_pkg.sv @@
// shared types and constants for the utf-8 stream decoder
package u8d_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CP_W     = 21;
    localparam int unsigned CNT_W    = 3;
    localparam int unsigned CONT_W   = 2;
    localparam int unsigned PAYLD_W  = 12;
    localparam int unsigned OUT_TDATA_W = 24;

    localparam logic [CP_W-1:0]  REPL_CP  = 21'h00FFFD;
    localparam logic [CNT_W-1:0] MAX_RESULTS = 3'd4;

    // continuation counts a lead byte can ask for
    localparam logic [CONT_W-1:0] NEED_NONE  = 2'd0;
    localparam logic [CONT_W-1:0] NEED_ONE   = 2'd1;
    localparam logic [CONT_W-1:0] NEED_TWO   = 2'd2;
    localparam logic [CONT_W-1:0] NEED_THREE = 2'd3;

    // results caused by one input byte: cnt-1 replacement characters then last_cp
    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [CP_W-1:0]  last_cp;
        logic             str_end;
    } burst_t;

endpackage

@@ rtl/core/u8d_decode.sv @@
// sequence state and per-byte decode into a result burst descriptor
module u8d_decode import u8d_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              byte_fire,
    input  logic [BYTE_W-1:0] byte_in,
    input  logic              string_end,
    output burst_t            burst,
    output logic              seq_pending
);

    logic [BYTE_W-1:0]  lead_reg,    lead_next;
    logic [CONT_W-1:0]  need_reg,    need_next;
    logic [CONT_W-1:0]  seen_reg,    seen_next;
    logic [PAYLD_W-1:0] payload_reg, payload_next;

    logic               is_cont;
    logic               pending;
    logic               complete;
    logic               buffer_cont;
    logic               broken;
    logic               fresh;
    logic               ascii;
    logic [CONT_W-1:0]  fresh_need;
    logic               fresh_one;
    logic               fresh_open;
    logic [CNT_W-1:0]   repl_n;
    logic [CP_W-1:0]    lead_sh;
    logic [CP_W-1:0]    seq_cp;
    logic [CP_W-1:0]    fresh_cp;

    assign is_cont  = (byte_in[7:6] == 2'b10);
    assign pending  = (need_reg != NEED_NONE);
    assign complete = pending && is_cont
                      && (({1'b0, seen_reg} + 3'd1) == {1'b0, need_reg});
    assign buffer_cont = pending && is_cont && !string_end && !complete;
    assign broken   = pending && !complete && !buffer_cont;
    assign fresh    = !pending || broken;
    assign repl_n   = broken ? ({1'b0, seen_reg} + 3'd1) : 3'd0;

    // lead byte class when the byte is taken on its own
    always_comb begin
        fresh_need = NEED_NONE;
        if (byte_in[7:5] == 3'b110) begin
            fresh_need = NEED_ONE;
        end else if (byte_in[7:4] == 4'b1110) begin
            fresh_need = NEED_TWO;
        end else if (byte_in[7:3] == 5'b11110) begin
            fresh_need = NEED_THREE;
        end
    end

    assign ascii      = !byte_in[7];
    assign fresh_one  = fresh && (ascii || (fresh_need == NEED_NONE) || string_end);
    assign fresh_open = fresh && !fresh_one && !ascii;
    assign fresh_cp   = ascii ? {13'd0, byte_in} : REPL_CP;

    always_comb begin
        case (need_reg)
            NEED_ONE:   lead_sh = {10'd0, lead_reg[4:0], 6'd0};
            NEED_TWO:   lead_sh = {5'd0, lead_reg[3:0], 12'd0};
            NEED_THREE: lead_sh = {lead_reg[2:0], 18'd0};
            default:    lead_sh = '0;
        endcase
    end

    assign seq_cp = lead_sh | {3'd0, payload_reg, 6'd0} | {15'd0, byte_in[5:0]};

    always_comb begin
        burst.str_end = string_end;
        if (complete) begin
            burst.cnt     = 3'd1;
            burst.last_cp = seq_cp;
        end else begin
            burst.cnt     = repl_n + {2'd0, fresh_one};
            burst.last_cp = fresh_one ? fresh_cp : REPL_CP;
        end
    end

    always_comb begin
        lead_next    = lead_reg;
        need_next    = need_reg;
        seen_next    = seen_reg;
        payload_next = payload_reg;
        if (complete || broken || string_end) begin
            lead_next    = '0;
            need_next    = NEED_NONE;
            seen_next    = '0;
            payload_next = '0;
        end
        if (buffer_cont) begin
            payload_next = {payload_reg[5:0], byte_in[5:0]};
            seen_next    = seen_reg + 2'd1;
        end
        if (fresh_open) begin
            lead_next    = byte_in;
            need_next    = fresh_need;
            seen_next    = '0;
            payload_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lead_reg    <= '0;
            need_reg    <= NEED_NONE;
            seen_reg    <= '0;
            payload_reg <= '0;
        end else if (byte_fire) begin
            lead_reg    <= lead_next;
            need_reg    <= need_next;
            seen_reg    <= seen_next;
            payload_reg <= payload_next;
        end
    end

    assign seq_pending = pending;

endmodule

@@ rtl/core/utf8_stream_decoder.sv @@
// top level of the utf-8 stream decoder with replacement character output
//
//  channel  | direction | tdata (lowest bit up)        | tlast            | tuser
//  s_       | in        | byte_in[7:0]                 | string_end       | -
//  m_       | out       | code_point[20:0], 3'b0 pad   | run_last         | final_of_string
//
//  an input byte is decoded in the cycle it is accepted; its results are held in a
//  burst descriptor register and then drained by the output register, one per ready cycle
//  one byte per cycle sustained while each byte gives at most one result and m_tready
//  is high; a byte that breaks a sequence gives up to four results, sent one by one
//  the descriptor register lets a new byte be accepted while a result waits on m_tready
//  reset (aresetn low, synchronous) clears the sequence state and empties both stages
module utf8_stream_decoder import u8d_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [BYTE_W-1:0]      s_tdata,   // byte_in[7:0]
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // code_point[20:0], zero pad [23:21]
    output logic                   m_tlast,
    output logic                   m_tuser    // final_of_string
);

    logic             s_fire;
    logic             m_fire;
    burst_t           dec_burst;
    logic             seq_pending;

    // descriptor stage between decode and output
    logic             s1_valid_reg, s1_valid_next;
    burst_t           s1_burst_reg;
    logic             s1_move;

    // output stage: results still to send for the current byte
    logic [CNT_W-1:0] s2_rem_reg, s2_rem_next;
    logic [CP_W-1:0]  s2_cp_reg;
    logic             s2_end_reg;
    logic             s2_free;

    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;

    u8d_decode u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_fire   (s_fire),
        .byte_in     (s_tdata),
        .string_end  (s_tlast),
        .burst       (dec_burst),
        .seq_pending (seq_pending)
    );

    // output stage frees up when empty or on its final transaction
    assign s2_free  = (s2_rem_reg == 3'd0) || ((s2_rem_reg == 3'd1) && m_tready);
    assign s1_move  = s1_valid_reg && s2_free;
    assign s_tready = !s1_valid_reg || s1_move;

    // bytes that only buffer part of a sequence leave no descriptor
    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_fire && (dec_burst.cnt != 3'd0)) begin
            s1_valid_next = 1'b1;
        end else if (s1_move) begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb begin
        s2_rem_next = s2_rem_reg;
        if (s1_move) begin
            s2_rem_next = s1_burst_reg.cnt;
        end else if (m_fire) begin
            s2_rem_next = s2_rem_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_rem_reg   <= '0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_rem_reg   <= s2_rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_burst_reg <= dec_burst;
        end
        if (s1_move) begin
            s2_cp_reg  <= s1_burst_reg.last_cp;
            s2_end_reg <= s1_burst_reg.str_end;
        end
    end

    // every result but the last of a burst is a replacement character
    assign m_tvalid = (s2_rem_reg != 3'd0);
    assign m_tlast  = (s2_rem_reg == 3'd1);
    assign m_tuser  = m_tlast && s2_end_reg;
    assign m_tdata  = {3'd0, (m_tlast ? s2_cp_reg : REPL_CP)};

`ifndef NO_ASSERTIONS
    // a held descriptor always carries at least one result
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> (s1_burst_reg.cnt != 3'd0))
        else $error("empty burst descriptor held");

    // no byte gives more than four results
    assert property (@(posedge aclk) disable iff (!aresetn)
        s2_rem_reg <= MAX_RESULTS)
        else $error("result count out of range");

    // the end of a string always leaves the decoder idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tlast) |=> !seq_pending)
        else $error("sequence left pending after string end");

    // results ahead of the last one in a burst are replacement characters
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[CP_W-1:0] == REPL_CP) && !m_tuser)
        else $error("non-final burst result is not a replacement");
`endif

endmodule

@@ test/utf8_stream_decoder_test.sv @@
// self-checking testbench for the utf-8 stream decoder with replacement character output
`timescale 1ns / 100ps

module utf8_stream_decoder_test;
    import u8d_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 250;

    // one byte waiting to be offered on s_, hold makes the sender wait for a full drain
    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              hold;
    } byte_item_t;

    // one code point transaction expected on m_
    typedef struct {
        logic [CP_W-1:0] cp;
        logic            run_last;
        logic            str_done;
    } code_point_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [BYTE_W-1:0]      s_tdata  = '0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;

    byte_item_t  bytes_to_send[$];
    code_point_t pending_cps[$];
    logic [CP_W-1:0] step_cps[$];

    // decoder state as the testbench sees it
    logic [BYTE_W-1:0]  seq_lead;
    logic [CONT_W-1:0]  seq_need;
    logic [CONT_W-1:0]  seq_seen;
    logic [PAYLD_W-1:0] seq_bits;

    int   cycle_cnt    = 0;
    int   mismatch_cnt = 0;
    int   gap_left     = 0;
    int   stall_left   = 0;
    logic byte_taken   = 1'b0;

    utf8_stream_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // byte_in[7:0]
        .s_tlast  (s_tlast),   // string_end
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // code_point[20:0], zero pad [23:21]
        .m_tlast  (m_tlast),   // run_last
        .m_tuser  (m_tuser)    // final_of_string
    );

    always #10 aclk = ~aclk;

    // continuations that a lead byte asks for, none for ascii, stray or invalid bytes
    function automatic logic [CONT_W-1:0] lead_need(input logic [BYTE_W-1:0] b);
        if (b[7:5] == 3'b110)
            return NEED_ONE;
        if (b[7:4] == 4'b1110)
            return NEED_TWO;
        if (b[7:3] == 5'b11110)
            return NEED_THREE;
        return NEED_NONE;
    endfunction

    function automatic void clear_sequence();
        seq_lead = '0;
        seq_need = NEED_NONE;
        seq_seen = '0;
        seq_bits = '0;
    endfunction

    // byte handled with no sequence pending
    function automatic void fresh_byte(input logic [BYTE_W-1:0] b, input logic e);
        logic [CONT_W-1:0] need;
        need = lead_need(b);
        if (!b[7]) begin
            step_cps.insert(step_cps.size(), {13'b0, b});
        end else if (need == NEED_NONE || e) begin
            step_cps.insert(step_cps.size(), REPL_CP);
        end else begin
            seq_lead = b;
            seq_need = need;
            seq_seen = '0;
            seq_bits = '0;
        end
    endfunction

    // works out the code points that one accepted byte causes and queues them
    function automatic void decode_byte(input logic [BYTE_W-1:0] b, input logic e);
        logic        is_cont;
        logic [CP_W-1:0] cp;
        code_point_t want;
        is_cont = (b[7:6] == 2'b10);
        step_cps.delete();
        if (seq_need != NEED_NONE) begin
            if (is_cont && int'(seq_seen) + 1 == int'(seq_need)) begin
                case (seq_need)
                    NEED_ONE: cp = {10'b0, seq_lead[4:0], b[5:0]};
                    NEED_TWO: cp = {5'b0, seq_lead[3:0], seq_bits[5:0], b[5:0]};
                    default:  cp = {seq_lead[2:0], seq_bits[11:0], b[5:0]};
                endcase
                step_cps.insert(step_cps.size(), cp);
                clear_sequence();
            end else if (is_cont && !e) begin
                seq_bits = {seq_bits[5:0], b[5:0]};
                seq_seen = seq_seen + 2'd1;
            end else begin
                // broken sequence: one replacement for the lead and each buffered continuation
                for (int i = 0; i <= int'(seq_seen); i++)
                    step_cps.insert(step_cps.size(), REPL_CP);
                clear_sequence();
                fresh_byte(b, e);
            end
        end else begin
            fresh_byte(b, e);
        end
        if (e)
            clear_sequence();
        foreach (step_cps[i]) begin
            want.cp       = step_cps[i];
            want.run_last = (i == step_cps.size() - 1);
            want.str_done = want.run_last && e;
            pending_cps.insert(pending_cps.size(), want);
        end
    endfunction

    // no idling near the end of the run and in every third window of the cycle counter
    function automatic bit idling_off();
        return bytes_to_send.size() < 40 || (cycle_cnt / 400) % 3 == 2;
    endfunction

    task automatic put_byte(input logic [BYTE_W-1:0] b, input logic e, input logic h = 1'b0);
        byte_item_t item;
        item.data = b;
        item.last = e;
        item.hold = h;
        bytes_to_send.insert(bytes_to_send.size(), item);
    endtask

    // sampling at the rising edge: result check first, then prediction of the input transaction
    always @(posedge aclk) begin
        code_point_t want;
        cycle_cnt <= cycle_cnt + 1;
        byte_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_cps.size() == 0) begin
                if (mismatch_cnt < 10)
                    $display("unexpected transaction: cp=%h last=%b final=%b",
                             m_tdata, m_tlast, m_tuser);
                mismatch_cnt++;
            end else begin
                want = pending_cps.pop_front();
                if (m_tdata !== {3'b000, want.cp} || m_tlast !== want.run_last
                        || m_tuser !== want.str_done) begin
                    if (mismatch_cnt < 10)
                        $display("mismatch: expected cp=%h last=%b final=%b, got cp=%h last=%b final=%b",
                                 want.cp, want.run_last, want.str_done,
                                 m_tdata, m_tlast, m_tuser);
                    mismatch_cnt++;
                end
            end
        end
        if (aresetn && s_tvalid && s_tready)
            decode_byte(s_tdata, s_tlast);
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // sender: offers the next byte at the falling edge once the current one has gone
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !byte_taken) begin
            // transaction still waiting for s_tready
        end else if (gap_left != 0) begin
            s_tvalid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (bytes_to_send.size() == 0) begin
            s_tvalid <= 1'b0;
        end else if (bytes_to_send[0].hold && pending_cps.size() != 0) begin
            // pause until every outstanding code point has been taken
            s_tvalid <= 1'b0;
        end else if (!idling_off() && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            gap_left <= $urandom_range(0, 6);
        end else begin
            s_tvalid <= 1'b1;
            s_tdata  <= bytes_to_send[0].data;
            s_tlast  <= bytes_to_send[0].last;
            void'(bytes_to_send.pop_front());
        end
    end

    // receiver: back-pressure in random bursts
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!idling_off() && $urandom_range(0, 4) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 6);
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin
        logic [BYTE_W-1:0] chunk[$];
        int directed_cnt;
        int n_conts;
        int n_sent;
        int str_len;
        int pick;
        logic [CONT_W-1:0] need;
        logic first_random;

        clear_sequence();

        // ascii extremes, the second one closing a string
        put_byte(8'h00, 1'b0);
        put_byte(8'h7F, 1'b1);
        // two, three and four byte forms, the largest code point among them
        put_byte(8'hC2, 1'b0);
        put_byte(8'hA9, 1'b0);
        put_byte(8'hE2, 1'b0);
        put_byte(8'h82, 1'b0);
        put_byte(8'hAC, 1'b0);
        put_byte(8'hF7, 1'b0);
        put_byte(8'hBF, 1'b0);
        put_byte(8'hBF, 1'b0);
        put_byte(8'hBF, 1'b1);
        // stray continuation and invalid lead
        put_byte(8'h80, 1'b0);
        put_byte(8'hFF, 1'b0);
        // four byte sequence broken by ascii: three replacements then the letter
        put_byte(8'hF0, 1'b0);
        put_byte(8'h9F, 1'b0);
        put_byte(8'h98, 1'b0);
        put_byte(8'h41, 1'b0);
        // lead byte carrying the end of the string
        put_byte(8'hE2, 1'b1);
        // string ends on a continuation that does not complete the sequence
        put_byte(8'hF0, 1'b0);
        put_byte(8'h9F, 1'b0);
        put_byte(8'h98, 1'b1);
        // lead broken by an invalid byte at the end of the string
        put_byte(8'hC2, 1'b0);
        put_byte(8'hF8, 1'b1);
        // surrogate range decodes without complaint
        put_byte(8'hED, 1'b0);
        put_byte(8'hA0, 1'b0);
        put_byte(8'h80, 1'b1);
        directed_cnt = bytes_to_send.size();

        // random strings, mostly well formed, with noise and truncated sequences
        first_random = 1'b1;
        while (bytes_to_send.size() < directed_cnt + RANDOM_BYTES) begin
            str_len = $urandom_range(1, 8);
            for (int c = 0; c < str_len; c++) begin
                chunk.delete();
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    chunk.insert(chunk.size(), 8'($urandom_range(0, 255)));
                end else begin
                    case ($urandom_range(0, 3))
                        0:       need = NEED_NONE;
                        1:       need = NEED_ONE;
                        2:       need = NEED_TWO;
                        default: need = NEED_THREE;
                    endcase
                    case (need)
                        NEED_NONE:  chunk.insert(chunk.size(), {1'b0, 7'($urandom)});
                        NEED_ONE:   chunk.insert(chunk.size(), {3'b110, 5'($urandom)});
                        NEED_TWO:   chunk.insert(chunk.size(), {4'b1110, 4'($urandom)});
                        default:    chunk.insert(chunk.size(), {5'b11110, 3'($urandom)});
                    endcase
                    n_conts = int'(need);
                    // truncated sequence now and then
                    if (pick < 18 && n_conts > 0)
                        n_conts = $urandom_range(0, n_conts - 1);
                    for (int k = 0; k < n_conts; k++)
                        chunk.insert(chunk.size(), {2'b10, 6'($urandom)});
                end
                foreach (chunk[j])
                    put_byte(chunk[j], (c == str_len - 1) && (j == chunk.size() - 1),
                             first_random || $urandom_range(0, 49) == 0);
                first_random = 1'b0;
            end
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (bytes_to_send.size() != 0 || s_tvalid || pending_cps.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (mismatch_cnt == 0 && pending_cps.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
